[src/mcdb_pkg.sv]
// Shared widths, reset value and result type for the multi-channel debouncer.
`default_nettype none

package mcdb_pkg;

    localparam int MAX_CHANNELS = 32;
    localparam int DATA_W       = 32;
    localparam int TIME_W       = 32;
    localparam int DEB_W        = 16;

    localparam logic [DEB_W-1:0] DEB_RESET = 16'd20;

    typedef struct packed {
        logic [DATA_W-1:0] debounced;
        logic [DATA_W-1:0] prior_debounced;
    } mcdb_result_t;

endpackage

`default_nettype wire

[src/mcdb_lane.sv]
// One debounce lane: change time, previous raw bit and committed bit of a channel.
`default_nettype none

module mcdb_lane (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        raw_bit,
    input  wire logic [mcdb_pkg::TIME_W-1:0] now_ms,
    input  wire logic [mcdb_pkg::DEB_W-1:0]  debounce_time,
    output logic                             committed,
    output logic                             committed_upd
);

    import mcdb_pkg::*;

    logic              committed_reg;
    logic              committed_next;
    logic              last_raw_reg;
    logic [TIME_W-1:0] change_time_reg;
    logic [TIME_W-1:0] change_time_next;
    logic [TIME_W-1:0] elapsed;

    assign elapsed = now_ms - change_time_reg;

    always_comb
    begin
        committed_next   = committed_reg;
        change_time_next = change_time_reg;
        if (raw_bit != committed_reg)
        begin
            if (raw_bit == last_raw_reg)
            begin
                // stable long enough: commit the new level
                if (elapsed >= TIME_W'(debounce_time))
                begin
                    committed_next = raw_bit;
                end
            end
            else
            begin
                // edge seen: restart the timer
                change_time_next = now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            committed_reg   <= 1'b0;
            last_raw_reg    <= 1'b0;
            change_time_reg <= '0;
        end
        else if (en)
        begin
            committed_reg   <= committed_next;
            last_raw_reg    <= raw_bit;
            change_time_reg <= change_time_next;
        end
    end

    assign committed     = committed_reg;
    assign committed_upd = committed_next;

endmodule

`default_nettype wire

[src/mcdb_merge.sv]
// Merge stage: holds lane results in an output register with a skid entry behind it.
`default_nettype none

module mcdb_merge (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire mcdb_pkg::mcdb_result_t result_in,
    output logic                      full,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output mcdb_pkg::mcdb_result_t    result_out
);

    import mcdb_pkg::*;

    logic         out_valid_reg;
    logic         out_valid_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    mcdb_result_t out_data_reg;
    mcdb_result_t skid_data_reg;
    logic         out_xfer;
    logic         out_free;

    assign out_xfer = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            // drain skid entry into the output register
            if (out_xfer)
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (load)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_valid_next = 1'b1;
            end
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_xfer)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (load)
        begin
            if (out_free)
            begin
                out_data_reg <= result_in;
            end
            else
            begin
                skid_data_reg <= result_in;
            end
        end
    end

    assign full       = skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign result_out = out_data_reg;

endmodule

`default_nettype wire

[src/multi_channel_input_debouncer_core.sv]
// Top level of the multi-channel input debouncer: lanes, merge stage, config register.
//
//   channel   direction  handshake            payload
//   in        to core    in_valid / in_stall  raw_sample[31:0], now_ms[31:0]
//   out       from core  out_valid / out_stall debounced[31:0], prior_debounced[31:0]
//   cfg       to core    cfg_wr_en            cfg_wr_data[15:0] (debounce time, ms)
//
// One item per cycle while in_stall is low: every channel has its own lane with
// a 32-bit subtract and compare, all lanes update in the cycle of the input transfer.
// The output register takes the result, or the skid entry does while output stalls.
// A skid entry behind the output register keeps input open for one more item
// while a result waits; in_stall rises only when the skid entry is full.
// Reset clears all lane state and loads a debounce time of 20 ms.
`default_nettype none

module multi_channel_input_debouncer_core #(
    parameter int NUM_CHANNELS = mcdb_pkg::MAX_CHANNELS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [mcdb_pkg::DATA_W-1:0] raw_sample,
    input  wire logic [mcdb_pkg::TIME_W-1:0] now_ms,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [mcdb_pkg::DATA_W-1:0]      debounced,
    output logic [mcdb_pkg::DATA_W-1:0]      prior_debounced,
    input  wire logic                        cfg_wr_en,
    input  wire logic [mcdb_pkg::DEB_W-1:0]  cfg_wr_data
);

    import mcdb_pkg::*;

    logic [DEB_W-1:0]        debounce_time_reg;
    logic                    accept;
    logic                    merge_full;
    logic [NUM_CHANNELS-1:0] lane_committed;
    logic [NUM_CHANNELS-1:0] lane_upd;
    mcdb_result_t            result_in;
    mcdb_result_t            result_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_time_reg <= DEB_RESET;
        end
        else if (cfg_wr_en)
        begin
            debounce_time_reg <= cfg_wr_data;
        end
    end

    assign in_stall = merge_full;
    assign accept   = in_valid && !merge_full;

    for (genvar k = 0; k < NUM_CHANNELS; k++)
    begin : g_lane
        mcdb_lane u_lane (
            .clk           (clk),
            .rst_n         (rst_n),
            .en            (accept),
            .raw_bit       (raw_sample[k]),
            .now_ms        (now_ms),
            .debounce_time (debounce_time_reg),
            .committed     (lane_committed[k]),
            .committed_upd (lane_upd[k])
        );
    end

    // channels above the lane count stay at zero
    assign result_in.debounced       = DATA_W'(lane_upd);
    assign result_in.prior_debounced = DATA_W'(lane_committed);

    mcdb_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .result_in  (result_in),
        .full       (merge_full),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_out (result_out)
    );

    assign debounced       = result_out.debounced;
    assign prior_debounced = result_out.prior_debounced;

endmodule

`default_nettype wire

[sim/multi_channel_input_debouncer_core_tb.sv]
// Testbench for the multi-channel input debouncer core: directed and random traffic against a predictor.
module multi_channel_input_debouncer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcdb_pkg::*;

    class debounce_tracker;
        logic [DEB_W-1:0]  deb_time;
        logic [DATA_W-1:0] committed;
        logic [DATA_W-1:0] last_raw;
        logic [TIME_W-1:0] change_at [MAX_CHANNELS];
        mcdb_result_t      levels_due [$];
        int                errors;

        function new();
            deb_time  = DEB_RESET;
            committed = '0;
            last_raw  = '0;
            foreach (change_at[k])
                change_at[k] = '0;
            errors = 0;
        endfunction

        function void set_debounce(logic [DEB_W-1:0] value);
            deb_time = value;
        endfunction

        // Advance the lane state by one accepted transfer and queue its levels.
        function void take_sample(logic [DATA_W-1:0] raw, logic [TIME_W-1:0] now);
            mcdb_result_t      want;
            logic [TIME_W-1:0] elapsed;
            want.prior_debounced = committed;
            for (int k = 0; k < MAX_CHANNELS; k++)
            begin
                if (raw[k] != committed[k])
                begin
                    if (raw[k] == last_raw[k])
                    begin
                        elapsed = now - change_at[k];
                        if (elapsed >= {{(TIME_W-DEB_W){1'b0}}, deb_time})
                            committed[k] = raw[k];
                    end
                    else
                    begin
                        change_at[k] = now;
                    end
                end
            end
            last_raw = raw;
            want.debounced = committed;
            levels_due.push_back(want);
        endfunction

        function void check_levels(logic [DATA_W-1:0] deb, logic [DATA_W-1:0] prior);
            mcdb_result_t want;
            if (levels_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual debounced %h prior %h",
                         $time, deb, prior);
                errors++;
                return;
            end
            want = levels_due.pop_front();
            if (deb !== want.debounced)
            begin
                $display("%0t: debounced mismatch, expected %h actual %h",
                         $time, want.debounced, deb);
                errors++;
            end
            if (prior !== want.prior_debounced)
            begin
                $display("%0t: prior_debounced mismatch, expected %h actual %h",
                         $time, want.prior_debounced, prior);
                errors++;
            end
        endfunction

        function int pending();
            return levels_due.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [DATA_W-1:0] raw_sample = '0;
    logic [TIME_W-1:0] now_ms = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DATA_W-1:0] debounced;
    logic [DATA_W-1:0] prior_debounced;
    logic              cfg_wr_en = 1'b0;
    logic [DEB_W-1:0]  cfg_wr_data = '0;

    debounce_tracker   tracker;
    logic              steady = 1'b0;
    logic [TIME_W-1:0] cur_time = '0;
    logic [DATA_W-1:0] cur_raw = '0;

    multi_channel_input_debouncer_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .raw_sample      (raw_sample),
        .now_ms          (now_ms),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .debounced       (debounced),
        .prior_debounced (prior_debounced),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= steady ? 1'b0 : ($urandom_range(99, 0) < 34);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_levels(debounced, prior_debounced);
    end

    // Hold the sample until the transfer, then note it; valid stays high on return.
    task automatic send_sample(logic [DATA_W-1:0] raw, logic [TIME_W-1:0] now);
        while (!steady && $urandom_range(99, 0) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        raw_sample <= raw;
        now_ms     <= now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.take_sample(raw, now);
    endtask

    // Drain all results, then write the debounce time.
    task automatic reconfigure(logic [DEB_W-1:0] value);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_debounce(value);
    endtask

    task automatic run_phase(logic [DEB_W-1:0] deb, int count);
        int unsigned       pick;
        logic [DATA_W-1:0] raw;
        logic [TIME_W-1:0] now;
        reconfigure(deb);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 8)
            begin
                // noise: a glitch sample, sometimes with a stray time stamp
                raw = $urandom();
                now = $urandom_range(1, 0) ? $urandom() : cur_time;
            end
            else
            begin
                pick = $urandom_range(99, 0);
                if (pick < 70)
                    cur_time += $urandom_range(3, 0);
                else if (pick < 92)
                    cur_time += $urandom_range(2 * deb + 2, 0);
                else
                    cur_time += $urandom_range(70000, 0);
                pick = $urandom_range(99, 0);
                if (pick < 30)
                    cur_raw ^= 32'h1 << $urandom_range(31, 0);
                else if (pick < 40)
                    cur_raw ^= $urandom() & $urandom() & $urandom();
                raw = cur_raw;
                now = cur_time;
            end
            send_sample(raw, now);
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset debounce time of 20 ms
        send_sample(32'h0000_0000, 32'h0000_0000);
        send_sample(32'hFFFF_FFFF, 32'h0000_0005);
        send_sample(32'hFFFF_FFFF, 32'h0000_000A);
        send_sample(32'hFFFF_FFFF, 32'h0000_0019);
        send_sample(32'h0000_0000, 32'h0000_001E);
        send_sample(32'h0000_FFFF, 32'h0000_001F);
        send_sample(32'h0000_FFFF, 32'h0000_0032);
        // time stamp wraps between change and commit
        send_sample(32'hFFFF_0000, 32'hFFFF_FFF0);
        send_sample(32'hFFFF_0000, 32'hFFFF_FFFF);
        send_sample(32'hFFFF_0000, 32'h0000_0004);
        send_sample(32'h0000_0000, 32'h0000_0000);

        // zero debounce time: a stable change commits at once
        reconfigure(16'd0);
        send_sample(32'hAAAA_AAAA, 32'h0000_0064);
        send_sample(32'hAAAA_AAAA, 32'h0000_0064);
        send_sample(32'h5555_5555, 32'hFFFF_FFFF);
        send_sample(32'h5555_5555, 32'hFFFF_FFFF);

        // longest debounce time
        reconfigure(16'hFFFF);
        send_sample(32'hAAAA_AAAA, 32'h0000_00C8);
        send_sample(32'hAAAA_AAAA, 32'h0001_00C6);
        send_sample(32'hAAAA_AAAA, 32'h0001_00C7);
        send_sample(32'h0000_0000, 32'h8000_0000);
        send_sample(32'h0000_0000, 32'h0000_0000);

        run_phase(16'd20, 230);
        run_phase(16'd0, 230);
        cur_time = 32'hFFFF_FF00;
        run_phase(16'd1, 230);
        run_phase(16'd5, 230);
        run_phase(16'hFFFF, 230);
        run_phase(DEB_W'($urandom_range(40, 2)), 230);
        steady = 1'b1;
        run_phase(16'd12, 230);
        steady = 1'b0;
        run_phase(DEB_W'($urandom_range(65535, 0)), 230);

        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (tracker.errors == 0)
            $display("multi_channel_input_debouncer_core_tb: clean");
        else
            $display("multi_channel_input_debouncer_core_tb: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("multi_channel_input_debouncer_core_tb: errors");
        $finish;
    end

endmodule

[filelist.f]
src/mcdb_pkg.sv
src/mcdb_lane.sv
src/mcdb_merge.sv
src/multi_channel_input_debouncer_core.sv
sim/multi_channel_input_debouncer_core_tb.sv
